// ----- src/iwm_pkg.sv -----
`default_nettype none

package iwm_pkg;

    // Geometry of the file system (block size must be a power of two)
    localparam int BLOCK_BYTES  = 1024;
    localparam int DIRECT_COUNT = 7;
    localparam int DIRECT_MAX   = 7;
    localparam int DIR_IDX_W    = $clog2(DIRECT_MAX);
    localparam int BB_BITS      = $clog2(BLOCK_BYTES);
    localparam int PTRS         = BLOCK_BYTES / 2;
    localparam int PTR_BITS     = $clog2(PTRS);
    localparam int PTRS_SQ      = PTRS * PTRS;

    localparam int ZONE_W = 16;
    localparam int FB_W   = 32;
    localparam int ADDR_W = 26;

    localparam logic [ZONE_W-1:0] ZONE_LIMIT_RST = 16'd4096;

    // Input item kinds
    localparam logic REQ_MAP  = 1'b0;
    localparam logic REQ_RESP = 1'b1;

    // Result kinds
    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_FINAL = 1'b1;

    // Mapping status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EIO   = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic              req_type;
        logic [FB_W-1:0]   file_block;
        logic [ZONE_W-1:0] direct_zone_0;
        logic [ZONE_W-1:0] direct_zone_1;
        logic [ZONE_W-1:0] direct_zone_2;
        logic [ZONE_W-1:0] direct_zone_3;
        logic [ZONE_W-1:0] direct_zone_4;
        logic [ZONE_W-1:0] direct_zone_5;
        logic [ZONE_W-1:0] direct_zone_6;
        logic [ZONE_W-1:0] single_indirect_zone;
        logic [ZONE_W-1:0] double_indirect_zone;
        logic [ZONE_W-1:0] read_entry;
    } map_req_t;

    typedef struct packed {
        logic              result_kind;
        logic [ADDR_W-1:0] read_address;
        logic [1:0]        map_status;
        logic [ZONE_W-1:0] mapped_zone;
    } map_rsp_t;

    typedef logic [ZONE_W-1:0] cfg_word_t;

endpackage

`default_nettype wire

// ----- src/iwm_stream_if.sv -----
`default_nettype none

interface iwm_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- src/inode_block_map_walker.sv -----
// Inode block map walker.
// Channels: req (sink) takes map requests and memory read responses, told
// apart by req_type; rsp (source) gives either a read request for a 16-bit
// indirect entry or a final mapping; cfg (sink) writes zone_limit and is
// always ready. Write cfg only while no walk item is in flight.
// Path: an item taken on req waits in the input register, and its result
// is loaded into the result register when that item advances.
// Throughput: one item per cycle while rsp.ready holds; the input register
// and the result register form a two-entry pipeline, and all mapping work
// is one pass of logic between them, updating the walk phase as each item
// leaves the input register.
// A response that arrives with no walk pending yields no result.
// A new map request abandons any walk in progress.
// Reset: walk goes idle, pipeline empties, zone_limit returns to 4096.
// Stall: while rsp.ready is low the result holds; req stays ready until
// the input register also holds an item that has to produce a result.
`default_nettype none

module inode_block_map_walker (
    input  wire logic  clk,
    input  wire logic  rst_n,
    iwm_stream_if.sink   req,
    iwm_stream_if.source rsp,
    iwm_stream_if.sink   cfg
);
    import iwm_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_FINAL = 2'd1,
        PH_FIRST = 2'd2
    } phase_t;

    localparam int CALC_W = 48;

    phase_t                phase_reg, phase_next;
    logic [PTR_BITS-1:0]   inner_reg, inner_next;
    logic [ZONE_W-1:0]     limit_reg;
    logic                  stage_valid_reg;
    map_req_t              stage_data_reg;
    logic                  out_valid_reg;
    map_rsp_t              out_data_reg;

    map_rsp_t              res;
    logic                  has_res;
    logic                  adv;
    logic                  out_free;
    logic [ZONE_W-1:0]     zones [DIRECT_MAX];
    logic [FB_W-1:0]       fb1, fb2;

    function automatic map_rsp_t make_final(logic [1:0] status, logic [ZONE_W-1:0] zone);
        map_rsp_t r;
        r.result_kind  = KIND_FINAL;
        r.read_address = '0;
        r.map_status   = status;
        r.mapped_zone  = (status == ST_OK) ? zone : '0;
        return r;
    endfunction

    function automatic map_rsp_t make_read(logic [ZONE_W-1:0] zone, logic [PTR_BITS-1:0] idx);
        map_rsp_t        r;
        logic [CALC_W-1:0] sum;
        sum = (CALC_W'(zone) << BB_BITS) + (CALC_W'(idx) << 1);
        r.result_kind  = KIND_READ;
        r.read_address = sum[ADDR_W-1:0];
        r.map_status   = ST_OK;
        r.mapped_zone  = '0;
        return r;
    endfunction

    // Direct zone table and block offsets
    assign zones[0] = stage_data_reg.direct_zone_0;
    assign zones[1] = stage_data_reg.direct_zone_1;
    assign zones[2] = stage_data_reg.direct_zone_2;
    assign zones[3] = stage_data_reg.direct_zone_3;
    assign zones[4] = stage_data_reg.direct_zone_4;
    assign zones[5] = stage_data_reg.direct_zone_5;
    assign zones[6] = stage_data_reg.direct_zone_6;
    assign fb1 = stage_data_reg.file_block - FB_W'(DIRECT_COUNT);
    assign fb2 = fb1 - FB_W'(PTRS);

    // Mapping logic for the item in the input register
    always_comb
    begin
        res        = '0;
        has_res    = 1'b0;
        phase_next = phase_reg;
        inner_next = inner_reg;
        if (stage_data_reg.req_type == REQ_RESP)
        begin
            unique case (phase_reg)
                PH_FINAL:
                begin
                    has_res    = 1'b1;
                    phase_next = PH_IDLE;
                    if (stage_data_reg.read_entry >= limit_reg)
                        res = make_final(ST_EIO, '0);
                    else
                        res = make_final(ST_OK, stage_data_reg.read_entry);
                end
                PH_FIRST:
                begin
                    has_res = 1'b1;
                    if (stage_data_reg.read_entry == '0)
                    begin
                        phase_next = PH_IDLE;
                        res        = make_final(ST_OK, '0);
                    end
                    else if (stage_data_reg.read_entry >= limit_reg)
                    begin
                        phase_next = PH_IDLE;
                        res        = make_final(ST_EIO, '0);
                    end
                    else
                    begin
                        phase_next = PH_FINAL;
                        res        = make_read(stage_data_reg.read_entry, inner_reg);
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
        else
        begin
            has_res    = 1'b1;
            phase_next = PH_IDLE;
            if (stage_data_reg.file_block < FB_W'(DIRECT_COUNT))
            begin
                if (zones[stage_data_reg.file_block[DIR_IDX_W-1:0]] >= limit_reg)
                    res = make_final(ST_EIO, '0);
                else
                    res = make_final(ST_OK, zones[stage_data_reg.file_block[DIR_IDX_W-1:0]]);
            end
            else if (fb1 < FB_W'(PTRS))
            begin
                if (stage_data_reg.single_indirect_zone == '0)
                    res = make_final(ST_OK, '0);
                else if (stage_data_reg.single_indirect_zone >= limit_reg)
                    res = make_final(ST_EIO, '0);
                else
                begin
                    phase_next = PH_FINAL;
                    res = make_read(stage_data_reg.single_indirect_zone,
                                    fb1[PTR_BITS-1:0]);
                end
            end
            else if (fb2 < FB_W'(PTRS_SQ))
            begin
                if (stage_data_reg.double_indirect_zone == '0)
                    res = make_final(ST_OK, '0);
                else if (stage_data_reg.double_indirect_zone >= limit_reg)
                    res = make_final(ST_EIO, '0);
                else
                begin
                    phase_next = PH_FIRST;
                    inner_next = fb2[PTR_BITS-1:0];
                    res = make_read(stage_data_reg.double_indirect_zone,
                                    fb2[2*PTR_BITS-1:PTR_BITS]);
                end
            end
            else
            begin
                res = make_final(ST_RANGE, '0);
            end
        end
    end

    // Handshake: the input register advances when its result has room, or when it yields no result
    assign out_free  = !out_valid_reg || rsp.ready;
    assign adv       = stage_valid_reg && (!has_res || out_free);
    assign req.ready = !stage_valid_reg || adv;
    assign cfg.ready = 1'b1;
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            inner_reg       <= '0;
            limit_reg       <= ZONE_LIMIT_RST;
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
                limit_reg <= cfg.data;
            if (req.ready)
                stage_valid_reg <= req.valid;
            if (adv)
            begin
                phase_reg <= phase_next;
                inner_reg <= inner_next;
            end
            if (adv && has_res)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
            stage_data_reg <= req.data;
        if (adv && has_res)
            out_data_reg <= res;
    end

    // Checks
    a_final_bad_no_zone: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.data.result_kind == KIND_FINAL && rsp.data.map_status != ST_OK)
        |-> (rsp.data.mapped_zone == '0))
        else $error("failed mapping carries a zone");

    a_read_starts_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && has_res && res.result_kind == KIND_READ) |=> (phase_reg != PH_IDLE))
        else $error("read request issued without a pending walk");

    a_idle_resp_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_valid_reg && stage_data_reg.req_type == REQ_RESP && phase_reg == PH_IDLE)
        |-> !has_res)
        else $error("response with no walk produced a result");

    a_final_ends_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && has_res && res.result_kind == KIND_FINAL) |=> (phase_reg == PH_IDLE))
        else $error("walk still pending after final mapping");

endmodule

`default_nettype wire
